FILE: rtl/lbf_pkg.sv
// Shared codes for the letterbox fit and pointer map unit.
package lbf_pkg;

  typedef enum logic [1:0] {
    CLASS_EXACT    = 2'd0,
    CLASS_INTEGER  = 2'd1,
    CLASS_BILINEAR = 2'd2
  } scale_class_t;

  localparam int unsigned CFG_ADDR_BITS = 4;

  localparam logic [1:0] REG_CLIENT_W = 2'd0;
  localparam logic [1:0] REG_CLIENT_H = 2'd1;
  localparam logic [1:0] REG_AUTH_W   = 2'd2;
  localparam logic [1:0] REG_AUTH_H   = 2'd3;

endpackage

FILE: rtl/lbf_div_cell.sv
// One restoring-division step: one quotient bit per cell, handed to the next cell.
module lbf_div_cell
  import lbf_pkg::*;
#(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] rem_i,
  input  logic [W-1:0] lo_i,
  input  logic [W-1:0] den_i,
  output logic [W-1:0] rem_o,
  output logic [W-1:0] lo_o,
  output logic [W-1:0] den_o
);

  logic [W:0] trial;
  logic [W:0] diff;
  logic       ge;

  assign trial = {rem_i, lo_i[W-1]};
  assign diff  = trial - {1'b0, den_i};
  assign ge    = (trial >= {1'b0, den_i});

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= ge ? diff[W-1:0] : trial[W-1:0];
      lo_o  <= {lo_i[W-2:0], ge};
      den_o <= den_i;
    end
  end

endmodule

FILE: rtl/lbf_div_chain.sv
// Row of W registered division cells: 2W-bit dividend over W-bit divisor.
module lbf_div_chain
  import lbf_pkg::*;
#(
  parameter int W = 16
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*W-1:0] num_i,
  input  logic [W-1:0]   den_i,
  output logic [W-1:0]   quo_o,
  output logic [W-1:0]   rem_o
);

  // dividend high half must be below the divisor for the quotient to fit
  logic [W-1:0] rem_w [W+1];
  logic [W-1:0] lo_w  [W+1];
  logic [W-1:0] den_w [W+1];

  assign rem_w[0] = num_i[2*W-1:W];
  assign lo_w[0]  = num_i[W-1:0];
  assign den_w[0] = den_i;

  for (genvar i = 0; i < W; i++) begin : g_cell
    lbf_div_cell #(.W(W)) u_cell (
      .clk   (clk),
      .en    (en),
      .rem_i (rem_w[i]),
      .lo_i  (lo_w[i]),
      .den_i (den_w[i]),
      .rem_o (rem_w[i+1]),
      .lo_o  (lo_w[i+1]),
      .den_o (den_w[i+1])
    );
  end

  assign quo_o = lo_w[W];
  assign rem_o = rem_w[W];

endmodule

FILE: rtl/letterbox_fit_and_pointer_map_unit.sv
// Letterbox fit and pointer map top level: config port, pipeline and division rows.
//
// Fully pipelined: one pointer transfer per cycle unless out_tready stalls the output. The
// datapath has two rows of DIM_BITS restoring-division cells (fit side, then class and
// pointer mapping in parallel rows). The whole pipeline holds while a result waits on
// out_tready. No clearing pass after reset; all four size registers reset to zero.
module letterbox_fit_and_pointer_map_unit
  import lbf_pkg::*;
#(
  parameter int DIM_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // pointer_x [D:0], pointer_y [2D+1:D+1], zero padded
  input  logic [((2 * (DIM_BITS + 1) + 7) / 8) * 8 - 1:0] in_tdata,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // fit_left, fit_top, fit_w, fit_h, scale_factor, authored_x, authored_y; zero padded
  output logic [((7 * DIM_BITS - 2 + 7) / 8) * 8 - 1:0] out_tdata,
  // scale_class [1:0], hit [2]
  output logic [2:0]               out_tuser,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0]              cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);

  localparam int D        = DIM_BITS;
  localparam int P        = 2 * DIM_BITS;
  localparam int IN_BITS  = ((2 * (DIM_BITS + 1) + 7) / 8) * 8;
  localparam int OUT_RAW  = 7 * DIM_BITS - 2;
  localparam int OUT_BITS = ((OUT_RAW + 7) / 8) * 8;

  // ---------------- configuration ----------------
  logic [D-1:0] cw_r, ch_r, aw_r, ah_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= '0;
      ch_r <= '0;
      aw_r <= '0;
      ah_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[3:2])
        REG_CLIENT_W: cw_r <= cfg_pwdata[D-1:0];
        REG_CLIENT_H: ch_r <= cfg_pwdata[D-1:0];
        REG_AUTH_W:   aw_r <= cfg_pwdata[D-1:0];
        REG_AUTH_H:   ah_r <= cfg_pwdata[D-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_CLIENT_W: cfg_prdata = 32'(cw_r);
      REG_CLIENT_H: cfg_prdata = 32'(ch_r);
      REG_AUTH_W:   cfg_prdata = 32'(aw_r);
      REG_AUTH_H:   cfg_prdata = 32'(ah_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic adv;
  logic out_valid_r;

  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_valid_r;

  // ---------------- stage 1: products ----------------
  logic               v1_r;
  logic [D:0]         px1_r, py1_r;
  logic [D-1:0]       cw1_r, ch1_r, aw1_r, ah1_r;
  logic [P-1:0]       pa1_r, pb1_r;
  logic               zero1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px1_r   <= in_tdata[D:0];
      py1_r   <= in_tdata[2*D+1:D+1];
      cw1_r   <= cw_r;
      ch1_r   <= ch_r;
      aw1_r   <= aw_r;
      ah1_r   <= ah_r;
      pa1_r   <= P'(cw_r) * P'(ah_r);
      pb1_r   <= P'(ch_r) * P'(aw_r);
      zero1_r <= (cw_r == '0) || (ch_r == '0) || (aw_r == '0) || (ah_r == '0);
    end
  end

  // ---------------- fit division row ----------------
  typedef struct packed {
    logic [D:0]   px;
    logic [D:0]   py;
    logic [D-1:0] cw;
    logic [D-1:0] ch;
    logic [D-1:0] aw;
    logic [D-1:0] ah;
    logic         zero;
    logic         wb;
  } fit_side_t;

  logic         wb1;
  logic [P-1:0] fnum;
  logic [D-1:0] fden;
  logic [D-1:0] fquo, frem;

  assign wb1  = (pa1_r <= pb1_r);
  assign fnum = wb1 ? pa1_r : pb1_r;
  assign fden = wb1 ? aw1_r : ah1_r;

  lbf_div_chain #(.W(D)) u_fit_div (
    .clk   (clk),
    .en    (adv),
    .num_i (fnum),
    .den_i (fden),
    .quo_o (fquo),
    .rem_o (frem)
  );

  fit_side_t fs_r [D];
  logic      fv_r [D];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < D; i++) fv_r[i] <= 1'b0;
    end else if (adv) begin
      fv_r[0] <= v1_r;
      for (int i = 1; i < D; i++) fv_r[i] <= fv_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fs_r[0] <= '{px: px1_r, py: py1_r, cw: cw1_r, ch: ch1_r, aw: aw1_r, ah: ah1_r,
                   zero: zero1_r, wb: wb1};
      for (int i = 1; i < D; i++) fs_r[i] <= fs_r[i-1];
    end
  end

  // ---------------- stage 3: fit size and offsets ----------------
  fit_side_t    ft;
  logic [D-1:0] w3, h3, lw, lh;

  assign ft = fs_r[D-1];
  assign w3 = ft.wb ? ft.cw : fquo;
  assign h3 = ft.wb ? fquo : ft.ch;
  assign lw = ft.cw - w3;
  assign lh = ft.ch - h3;

  logic           v3_r;
  logic [D:0]     px3_r, py3_r;
  logic [D-1:0]   w3_r, h3_r, aw3_r, ah3_r;
  logic [D-2:0]   left3_r, top3_r;
  logic           zero3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= fv_r[D-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px3_r   <= ft.px;
      py3_r   <= ft.py;
      w3_r    <= w3;
      h3_r    <= h3;
      aw3_r   <= ft.aw;
      ah3_r   <= ft.ah;
      left3_r <= lw[D-1:1];
      top3_r  <= lh[D-1:1];
      zero3_r <= ft.zero;
    end
  end

  // ---------------- stage 4: pointer offsets and inside test ----------------
  logic [D+1:0] dx, dy;
  logic         in_x, in_y;

  assign dx   = {px3_r[D], px3_r} - {3'b000, left3_r};
  assign dy   = {py3_r[D], py3_r} - {3'b000, top3_r};
  assign in_x = !dx[D+1] && (dx[D:0] < {1'b0, w3_r});
  assign in_y = !dy[D+1] && (dy[D:0] < {1'b0, h3_r});

  logic           v4_r;
  logic [D-1:0]   dx4_r, dy4_r, w4_r, h4_r, aw4_r, ah4_r;
  logic [D-2:0]   left4_r, top4_r;
  logic           zero4_r, hit4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx4_r   <= dx[D-1:0];
      dy4_r   <= dy[D-1:0];
      w4_r    <= w3_r;
      h4_r    <= h3_r;
      aw4_r   <= aw3_r;
      ah4_r   <= ah3_r;
      left4_r <= left3_r;
      top4_r  <= top3_r;
      zero4_r <= zero3_r;
      hit4_r  <= !zero3_r && in_x && in_y && (w3_r != '0) && (h3_r != '0);
    end
  end

  // ---------------- stage 5: mapping products ----------------
  logic           v5_r;
  logic [P-1:0]   mx5_r, my5_r;
  logic [D-1:0]   w5_r, h5_r, aw5_r, ah5_r;
  logic [D-2:0]   left5_r, top5_r;
  logic           zero5_r, hit5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (adv) v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // outside the fit these products are don't-care, the result is masked
      mx5_r   <= P'(dx4_r) * P'(aw4_r);
      my5_r   <= P'(dy4_r) * P'(ah4_r);
      w5_r    <= w4_r;
      h5_r    <= h4_r;
      aw5_r   <= aw4_r;
      ah5_r   <= ah4_r;
      left5_r <= left4_r;
      top5_r  <= top4_r;
      zero5_r <= zero4_r;
      hit5_r  <= hit4_r;
    end
  end

  // ---------------- class and mapping division rows ----------------
  logic [D-1:0] cxq, cxr, cyq, cyr, mxq, mxr, myq, myr;

  lbf_div_chain #(.W(D)) u_cx_div (
    .clk (clk), .en (adv), .num_i ({{D{1'b0}}, w5_r}), .den_i (aw5_r),
    .quo_o (cxq), .rem_o (cxr)
  );

  lbf_div_chain #(.W(D)) u_cy_div (
    .clk (clk), .en (adv), .num_i ({{D{1'b0}}, h5_r}), .den_i (ah5_r),
    .quo_o (cyq), .rem_o (cyr)
  );

  lbf_div_chain #(.W(D)) u_mx_div (
    .clk (clk), .en (adv), .num_i (mx5_r), .den_i (w5_r),
    .quo_o (mxq), .rem_o (mxr)
  );

  lbf_div_chain #(.W(D)) u_my_div (
    .clk (clk), .en (adv), .num_i (my5_r), .den_i (h5_r),
    .quo_o (myq), .rem_o (myr)
  );

  typedef struct packed {
    logic [D-1:0] w;
    logic [D-1:0] h;
    logic [D-1:0] aw;
    logic [D-1:0] ah;
    logic [D-2:0] left;
    logic [D-2:0] top;
    logic         zero;
    logic         hit;
  } map_side_t;

  map_side_t ms_r [D];
  logic      mv_r [D];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < D; i++) mv_r[i] <= 1'b0;
    end else if (adv) begin
      mv_r[0] <= v5_r;
      for (int i = 1; i < D; i++) mv_r[i] <= mv_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ms_r[0] <= '{w: w5_r, h: h5_r, aw: aw5_r, ah: ah5_r, left: left5_r, top: top5_r,
                   zero: zero5_r, hit: hit5_r};
      for (int i = 1; i < D; i++) ms_r[i] <= ms_r[i-1];
    end
  end

  // ---------------- output register ----------------
  map_side_t    mt;
  scale_class_t cls;
  logic [D-1:0] fac;
  logic         exact, integ;

  assign mt    = ms_r[D-1];
  assign exact = (mt.w == mt.aw) && (mt.h == mt.ah);
  assign integ = (cxr == '0) && (cyr == '0) && (cxq == cyq);

  always_comb begin
    priority if (mt.zero) begin
      cls = CLASS_BILINEAR;
      fac = '0;
    end else if (exact) begin
      cls = CLASS_EXACT;
      fac = D'(1);
    end else if (integ) begin
      cls = CLASS_INTEGER;
      fac = cxq;
    end else begin
      cls = CLASS_BILINEAR;
      fac = '0;
    end
  end

  logic [OUT_RAW-1:0] data_nxt;

  assign data_nxt = mt.zero ? '0 :
                    {mt.hit ? myq : {D{1'b0}}, mt.hit ? mxq : {D{1'b0}}, fac,
                     mt.h, mt.w, mt.top, mt.left};

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= mv_r[D-1];
  end

  logic [OUT_RAW-1:0] out_data_r;
  logic [2:0]         out_user_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= data_nxt;
      out_user_r <= {mt.hit && !mt.zero, cls};
    end
  end

  assign out_tdata = OUT_BITS'(out_data_r);
  assign out_tuser = out_user_r;

endmodule

FILE: tb/sv/letterbox_fit_and_pointer_map_unit_tb.sv
// Testbench for the letterbox fit and pointer map unit: stream stimulus with a scoreboard.
`timescale 1ns / 100ps

module letterbox_fit_and_pointer_map_unit_tb;
  import lbf_pkg::*;

  localparam int IN_W  = 40;
  localparam int OUT_W = 112;

  typedef struct packed {
    logic [14:0]  left;
    logic [14:0]  top;
    logic [15:0]  w;
    logic [15:0]  h;
    scale_class_t cls;
    logic [15:0]  fac;
    logic         hit;
    logic [15:0]  ax;
    logic [15:0]  ay;
  } fit_result_t;

  logic              clk;
  logic              rst_n;
  logic [IN_W-1:0]   in_tdata;
  logic              in_tvalid;
  logic              in_tready;
  logic [OUT_W-1:0]  out_tdata;
  logic [2:0]        out_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  // current size registers as written over the config port
  logic [15:0] client_w, client_h, auth_w, auth_h;
  bit          stall_on;

  class fit_scoreboard;
    fit_result_t pending_fits[$];
    int          errors;

    function void report(string msg);
      $display("MISMATCH %0t: %s", $realtime, msg);
      errors++;
    endfunction

    // letterbox fit of the current sizes and the mapping of one pointer
    function fit_result_t fit_and_map(logic [15:0] cw, logic [15:0] ch, logic [15:0] aw,
                                      logic [15:0] ah, logic signed [16:0] px,
                                      logic signed [16:0] py);
      fit_result_t r;
      longint w, h, lft, tp, dx, dy;
      r = '0;
      r.cls = CLASS_BILINEAR;
      if (cw != 0 && ch != 0 && aw != 0 && ah != 0) begin
        if (longint'(cw) * ah <= longint'(ch) * aw) begin
          w = cw;
          h = (longint'(cw) * ah) / aw;
        end else begin
          h = ch;
          w = (longint'(ch) * aw) / ah;
        end
        lft = (cw - w) / 2;
        tp = (ch - h) / 2;
        r.left = lft[14:0];
        r.top = tp[14:0];
        r.w = w[15:0];
        r.h = h[15:0];
        if (w == aw && h == ah) begin
          r.cls = CLASS_EXACT;
          r.fac = 16'd1;
        end else if (w % aw == 0 && h % ah == 0 && w / aw == h / ah) begin
          r.cls = CLASS_INTEGER;
          r.fac = 16'(w / aw);
        end
        dx = longint'(px) - lft;
        dy = longint'(py) - tp;
        if (w != 0 && h != 0 && dx >= 0 && dx < w && dy >= 0 && dy < h) begin
          r.hit = 1'b1;
          r.ax = 16'((dx * aw) / w);
          r.ay = 16'((dy * ah) / h);
        end
      end
      return r;
    endfunction

    function void note_pointer(logic [15:0] cw, logic [15:0] ch, logic [15:0] aw,
                               logic [15:0] ah, logic [IN_W-1:0] d);
      pending_fits.push_back(fit_and_map(cw, ch, aw, ah, d[16:0], d[33:17]));
    endfunction

    function void check_result(logic [OUT_W-1:0] d, logic [2:0] u);
      fit_result_t e;
      if (pending_fits.size() == 0) begin
        report("result transfer with nothing expected");
        return;
      end
      e = pending_fits.pop_front();
      if (d[14:0] !== e.left) report($sformatf("fit_left %0d exp %0d", d[14:0], e.left));
      if (d[29:15] !== e.top) report($sformatf("fit_top %0d exp %0d", d[29:15], e.top));
      if (d[45:30] !== e.w) report($sformatf("fit_w %0d exp %0d", d[45:30], e.w));
      if (d[61:46] !== e.h) report($sformatf("fit_h %0d exp %0d", d[61:46], e.h));
      if (d[77:62] !== e.fac) report($sformatf("scale_factor %0d exp %0d", d[77:62], e.fac));
      if (d[93:78] !== e.ax) report($sformatf("authored_x %0d exp %0d", d[93:78], e.ax));
      if (d[109:94] !== e.ay) report($sformatf("authored_y %0d exp %0d", d[109:94], e.ay));
      if (d[111:110] !== 2'b00) report("tdata padding not zero");
      if (u[1:0] !== e.cls) report($sformatf("scale_class %0d exp %0d", u[1:0], e.cls));
      if (u[2] !== e.hit) report($sformatf("hit %0b exp %0b", u[2], e.hit));
    endfunction
  endclass

  fit_scoreboard sb;

  letterbox_fit_and_pointer_map_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function int gap_len();
    int r;
    r = $urandom_range(99);
    if (!stall_on || r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic idle(int n);
    repeat (n) @(negedge clk);
  endtask

  task automatic write_size(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = {16'($urandom), val};  // upper bits must be dropped
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    case (idx)
      REG_CLIENT_W: client_w = val;
      REG_CLIENT_H: client_h = val;
      REG_AUTH_W:   auth_w = val;
      default:      auth_h = val;
    endcase
  endtask

  task automatic set_sizes(logic [15:0] cw, logic [15:0] ch, logic [15:0] aw,
                           logic [15:0] ah);
    write_size(REG_CLIENT_W, cw);
    write_size(REG_CLIENT_H, ch);
    write_size(REG_AUTH_W, aw);
    write_size(REG_AUTH_H, ah);
  endtask

  // called at a falling edge; returns at a falling edge after the transfer
  task automatic send_pointer(logic signed [16:0] px, logic signed [16:0] py);
    idle(gap_len());
    in_tdata = {6'b0, py, px};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_pointer(client_w, client_h, auth_w, auth_h, in_tdata);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (sb.pending_fits.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    idle(45);
  endtask

  // pointer near or inside the fitted rectangle, sometimes anywhere
  task automatic run_phase(int n);
      fit_result_t f;
      int lft, tp, w, h, r;
      logic signed [16:0] px, py;
      f = sb.fit_and_map(client_w, client_h, auth_w, auth_h, 0, 0);
      lft = f.left; tp = f.top; w = f.w; h = f.h;
      stall_on = ($urandom_range(3) != 0);
      send_pointer(17'(lft), 17'(tp));
      send_pointer(17'(lft + w - 1), 17'(tp + h - 1));
      send_pointer(17'(lft - 1), 17'(tp));
      send_pointer(17'(lft), 17'(tp - 1));
      send_pointer(17'(lft + w), 17'(tp));
      send_pointer(17'(lft), 17'(tp + h));
      send_pointer(-17'sd65536, -17'sd65536);
      send_pointer(17'sd65535, 17'sd65535);
      repeat (n) begin
        r = $urandom_range(9);
        if (r < 7 && w > 0 && h > 0) begin
          px = 17'(lft + $urandom_range(w - 1));
          py = 17'(tp + $urandom_range(h - 1));
        end else if (r < 9) begin
          px = 17'(lft + $urandom_range(w + 4) - 2);
          py = 17'(tp + $urandom_range(h + 4) - 2);
        end else begin
          px = 17'($urandom);
          py = 17'($urandom);
        end
        send_pointer(px, py);
      end
      wait_drained();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = 1'b1;
      repeat (gap_len()) @(negedge clk);
      if (stall_on) begin
        out_tready = 1'b0;
        repeat (gap_len()) @(negedge clk);
      end
    end
  end

  initial begin
    int k, aw, ah;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    client_w = '0; client_h = '0; auth_w = '0; auth_h = '0;
    stall_on = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_phase(8);                                 // all sizes zero after reset
    set_sizes(16'd640, 16'd480, 16'd640, 16'd480); // exact
    run_phase(20);
    set_sizes(16'd1920, 16'd1200, 16'd320, 16'd180); // integer multiple, letterboxed
    run_phase(20);
    set_sizes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(20);
    set_sizes(16'd1, 16'hFFFF, 16'hFFFF, 16'd1);   // fitted height floors to zero
    run_phase(10);
    set_sizes(16'hFFFF, 16'd3, 16'd7, 16'hFFFF);   // height binds, bilinear
    run_phase(20);
    set_sizes(16'd800, 16'd0, 16'd4, 16'd3);       // one size zero
    run_phase(10);

    repeat (20) begin
      k = $urandom_range(9);
      aw = $urandom_range(200, 1);
      ah = $urandom_range(200, 1);
      if (k < 4)
        set_sizes(16'(aw * (k + 1) + $urandom_range(30) * (k & 1)),
                  16'(ah * (k + 1) + $urandom_range(30) * (~k & 1)), 16'(aw), 16'(ah));
      else if (k < 7)
        set_sizes(16'($urandom_range(3000, 1)), 16'($urandom_range(3000, 1)),
                  16'($urandom_range(3000, 1)), 16'($urandom_range(3000, 1)));
      else if (k < 9)
        set_sizes(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      else
        set_sizes(16'($urandom_range(1)), 16'($urandom_range(3)),
                  16'($urandom_range(1)), 16'($urandom_range(65535, 65000)));
      run_phase(80);
    end

    if (sb.errors == 0 && sb.pending_fits.size() == 0) begin
      $display("simulation ok");
    end else begin
      if (sb.pending_fits.size() != 0) sb.report("results still expected at end");
      $display("simulation failed");
    end
    $finish;
  end

endmodule
